FILE: hdl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg - shared definitions for the seven-segment scanner
// Types, codes, widths and the segment table used across the block.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int unsigned DIGIT_COUNT_DEF = 8;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned SEG_W           = 8;
  localparam int unsigned LINES_W         = 3;
  localparam int unsigned CODE_W          = 4;
  localparam int unsigned STEP_W          = $clog2(VALUE_W);

  localparam logic [CODE_W-1:0]  BLANK_CODE = CODE_W'(10);
  localparam logic [CODE_W-1:0]  MAX_DIGIT  = CODE_W'(9);
  localparam logic [CODE_W-1:0]  DD_LIMIT   = CODE_W'(5);
  localparam logic [CODE_W-1:0]  DD_ADJUST  = CODE_W'(3);
  localparam logic [LINES_W-1:0] LINES_RST  = '1;
  localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(VALUE_W - 1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_LOAD = 2'd1,
    OP_FILL = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_CONV
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic tick;
    logic fill;
    logic load_start;
    logic conv_step;
    logic commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_full;
    logic conv_last;
  } sts_t;

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] pat;
    case (code)
      4'd0:    pat = 8'h3f;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5b;
      4'd3:    pat = 8'h4f;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6d;
      4'd6:    pat = 8'h7d;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7f;
      4'd9:    pat = 8'h6f;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

FILE: hdl/mss_in_if.sv
// ----------------------------------------------------------------------------
// mss_in_if - command channel of the scanner
// Valid/ready channel carrying operation and value.
// ----------------------------------------------------------------------------
interface mss_in_if;
  logic                         valid;
  logic                         ready;
  logic [mss_pkg::OP_W-1:0]     operation;
  logic [mss_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

FILE: hdl/mss_out_if.sv
// ----------------------------------------------------------------------------
// mss_out_if - display channel of the scanner
// Valid/ready channel carrying segment pattern and decoder select lines.
// ----------------------------------------------------------------------------
interface mss_out_if;
  logic                         valid;
  logic                         ready;
  logic [mss_pkg::SEG_W-1:0]    segments;
  logic [mss_pkg::LINES_W-1:0]  digit_lines;

  modport source (output valid, output segments, output digit_lines, input ready);
  modport sink   (input valid, input segments, input digit_lines, output ready);
endinterface

FILE: hdl/mss_ctrl.sv
// ----------------------------------------------------------------------------
// mss_ctrl - scanner controller
// Accepts items and sequences the 32-step number conversion.
// ----------------------------------------------------------------------------
module mss_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [mss_pkg::OP_W-1:0]  in_op_i,
  input  mss_pkg::sts_t             sts_i,
  output logic                      in_ready_o,
  output mss_pkg::cmd_t             cmd_o
);

  mss_pkg::state_e state_q, state_d;
  logic            accept;

  assign in_ready_o = (state_q == mss_pkg::ST_IDLE) && !sts_i.out_full;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mss_pkg::ST_IDLE: begin
        if (accept && (mss_pkg::op_e'(in_op_i) == mss_pkg::OP_LOAD)) begin
          state_d = mss_pkg::ST_CONV;
        end
      end
      mss_pkg::ST_CONV: begin
        if (sts_i.conv_last) begin
          state_d = mss_pkg::ST_IDLE;
        end
      end
      default: state_d = mss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      mss_pkg::ST_IDLE: begin
        if (accept) begin
          case (mss_pkg::op_e'(in_op_i))
            mss_pkg::OP_TICK: cmd_o.tick       = 1'b1;
            mss_pkg::OP_LOAD: cmd_o.load_start = 1'b1;
            mss_pkg::OP_FILL: cmd_o.fill       = 1'b1;
            default:          cmd_o            = '0; // unused code: dropped
          endcase
        end
      end
      mss_pkg::ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        cmd_o.commit    = sts_i.conv_last;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: hdl/mss_dpath.sv
// ----------------------------------------------------------------------------
// mss_dpath - scanner datapath
// Digit store, scan index, double-dabble converter and output register.
// ----------------------------------------------------------------------------
module mss_dpath #(
  parameter int unsigned DIGIT_COUNT = mss_pkg::DIGIT_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic [mss_pkg::VALUE_W-1:0]  value_i,
  input  mss_pkg::cmd_t                cmd_i,
  output mss_pkg::sts_t                sts_o,
  mss_out_if.source                    out_o
);

  localparam int unsigned IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int unsigned BCD_W = DIGIT_COUNT * mss_pkg::CODE_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGIT_COUNT - 1);

  logic [mss_pkg::CODE_W-1:0]  digit_q [DIGIT_COUNT];
  logic [IDX_W-1:0]            idx_q;
  logic [mss_pkg::LINES_W-1:0] sel_q;
  logic                        enable_q;
  logic [BCD_W-1:0]            bcd_q, bcd_d, adj;
  logic [mss_pkg::VALUE_W-1:0] bin_q;
  logic [mss_pkg::STEP_W-1:0]  step_q;
  logic                        out_valid_q;
  logic [mss_pkg::SEG_W-1:0]   seg_q;
  logic [mss_pkg::LINES_W-1:0] lines_q;
  logic [IDX_W+2:0]            idx_ext;
  logic [mss_pkg::LINES_W-1:0] lines_now;
  logic [mss_pkg::CODE_W-1:0]  fill_code;

  // one double-dabble step: add three to every digit of five or more, then shift
  always_comb begin
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      if (bcd_q[d*mss_pkg::CODE_W +: mss_pkg::CODE_W] >= mss_pkg::DD_LIMIT) begin
        adj[d*mss_pkg::CODE_W +: mss_pkg::CODE_W] =
          bcd_q[d*mss_pkg::CODE_W +: mss_pkg::CODE_W] + mss_pkg::DD_ADJUST;
      end else begin
        adj[d*mss_pkg::CODE_W +: mss_pkg::CODE_W] =
          bcd_q[d*mss_pkg::CODE_W +: mss_pkg::CODE_W];
      end
    end
    bcd_d = {adj[BCD_W-2:0], bin_q[mss_pkg::VALUE_W-1]};
  end

  assign idx_ext   = {3'b000, idx_q};
  assign lines_now = ~idx_ext[mss_pkg::LINES_W-1:0];
  assign fill_code = (value_i > 32'(mss_pkg::MAX_DIGIT)) ? mss_pkg::BLANK_CODE
                                                         : value_i[mss_pkg::CODE_W-1:0];

  assign sts_o.out_full  = out_valid_q && !out_o.ready;
  assign sts_o.conv_last = (step_q == mss_pkg::LAST_STEP);

  assign out_o.valid       = out_valid_q;
  assign out_o.segments    = seg_q;
  assign out_o.digit_lines = lines_q;

  // control state and digit store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_q[i] <= mss_pkg::BLANK_CODE;
      end
      idx_q       <= '0;
      sel_q       <= mss_pkg::LINES_RST;
      enable_q    <= 1'b1;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      if (cmd_i.tick) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.tick && enable_q) begin
        sel_q <= lines_now;
        idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
      end
      if (cmd_i.load_start) begin
        step_q <= '0;
      end else if (cmd_i.conv_step) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.fill) begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          digit_q[i] <= fill_code;
        end
      end else if (cmd_i.commit) begin
        // least significant digit goes to the last position
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          digit_q[i] <= bcd_d[(DIGIT_COUNT-1-i)*mss_pkg::CODE_W +: mss_pkg::CODE_W];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      bcd_q <= '0;
      bin_q <= value_i;
    end else if (cmd_i.conv_step) begin
      bcd_q <= bcd_d;
      bin_q <= {bin_q[mss_pkg::VALUE_W-2:0], 1'b0};
    end
    if (cmd_i.tick) begin
      if (enable_q) begin
        seg_q   <= mss_pkg::seg_pattern(digit_q[idx_q]);
        lines_q <= lines_now;
      end else begin
        seg_q   <= '0;
        lines_q <= sel_q;
      end
    end
  end

endmodule

FILE: hdl/multiplexed_seven_segment_scanner.sv
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_scanner - multiplexed seven-segment display driver
// Holds DIGIT_COUNT digit codes and scans them onto a shared segment bus.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : command items (operation, value). Tick, load number, fill digits.
//   out_o : one item per tick: segment pattern and decoder select lines.
//   cfg   : cfg_we_i/cfg_wdata_i write display_enable; write only when idle.
// Timing:
//   A tick is taken and its item sits in the output register the cycle
//   after. A load takes the item, then runs 32 double-dabble steps (one
//   per binary bit of value) in the converter, the last step writing the
//   digit store. No new item is taken while the converter loop runs.
// Stalls:
//   A finished tick item waits in the output register; the block takes a new
//   item in the cycle that item leaves, and is held off while it is stalled.
// Reset:
//   All digits blank, scan index 0, select lines 7, display enabled, output
//   register empty.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_scanner #(
  parameter int unsigned DIGIT_COUNT = mss_pkg::DIGIT_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  mss_in_if.sink     in_i,
  mss_out_if.source  out_o
);

  mss_pkg::cmd_t cmd;
  mss_pkg::sts_t sts;
  logic          in_ready;

  assign in_i.ready = in_ready;

  // sequencing: accepts items, runs the conversion loop
  mss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  // storage, converter and output register
  mss_dpath #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (in_i.value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_o)
  );

endmodule
